// File: design/mbs_pkg.sv
// shared types and constants for the merge and bubble sort core
package mbs_pkg;

   localparam int VALUE_W = 7;
   localparam int DATA_W  = 8;

   typedef logic [VALUE_W-1:0] value_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_LOAD,
      ST_SCAN,
      ST_WB,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_HOLD
   } state_type;

endpackage

// File: design/mbs_ram.sv
// generic single write, single read ram with registered read data
module mbs_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/merge_and_bubble_sort_core.sv
// merge and bubble sort core: gathers a batch, sorts it in ram, streams it out ascending
//
//   channel | dir | beat carries
//   --------+-----+-------------------------------------------------------------
//   req_    | in  | tdata[6:0] value, tlast end of batch
//   rsp_    | out | tdata[6:0] sorted value, tlast last of batch, tuser overflow
//
// an accepted beat is stored while the ram has room, else dropped; req_tready is high only while idle.
// the sort is bound by one ram read and one ram write per compare.
// each result passes through EMIT_RD, EMIT_LD and EMIT_HOLD, which waits on rsp_tready; stalls hold the beat.
// reset clears the sequencer, fill count and overflow flag; the ram needs no clearing.
module merge_and_bubble_sort_core #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [mbs_pkg::DATA_W-1:0]  req_tdata,  // [6:0] value, [7] zero
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mbs_pkg::DATA_W-1:0]  rsp_tdata,  // [6:0] sorted_value, [7] zero
   output logic                        rsp_tlast,
   output logic                        rsp_tuser   // [0] overflow
);
   import mbs_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);
   localparam logic [AW-1:0] LastAddr = AW'(MAX_ITEMS - 1);

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic [AW-1:0]   k_ff, k_in;
   logic [AW-1:0]   last_ff, last_in;
   logic [AW-1:0]   top_ff, top_in;
   logic [AW-1:0]   j_ff, j_in;
   value_type       carry_ff, carry_in;
   value_type       out_value_ff, out_value_in;
   logic            out_last_ff, out_last_in;

   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   value_type       ram_wdata;
   logic [AW-1:0]   ram_raddr;
   value_type       ram_rdata;

   logic            req_fire;
   logic            rsp_fire;
   logic            has_room;

   mbs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_EMIT_HOLD);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {{(DATA_W - VALUE_W){1'b0}}, out_value_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = dropped_ff;
   assign has_room   = (count_ff < MaxCount);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      last_ff      <= last_in;
      top_ff       <= top_in;
      j_ff         <= j_in;
      carry_ff     <= carry_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      top_in       = top_ff;
      j_in         = j_ff;
      carry_in     = carry_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = req_tdata[VALUE_W-1:0];
      ram_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (has_room) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_tlast) begin
                  // index of the last stored value of the batch
                  last_in = has_room ? count_ff[AW-1:0] : LastAddr;
                  top_in  = last_in;
                  j_in    = '0;
                  state_in = (last_in == '0) ? ST_EMIT_RD : ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            ram_raddr = '0;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            carry_in  = ram_rdata;
            ram_raddr = AW'(1);
            k_in      = AW'(1);
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // carry holds the largest seen this pass; smaller one drops back a slot
            ram_we    = 1'b1;
            ram_waddr = k_ff - AW'(1);
            if (carry_ff > ram_rdata) begin
               ram_wdata = ram_rdata;
            end else begin
               ram_wdata = carry_ff;
               carry_in  = ram_rdata;
            end
            if (k_ff == last_ff) begin
               state_in = ST_WB;
            end else begin
               ram_raddr = k_ff + AW'(1);
               k_in      = k_ff + AW'(1);
            end
         end
         ST_WB: begin
            ram_we    = 1'b1;
            ram_waddr = last_ff;
            ram_wdata = carry_ff;
            if (last_ff == AW'(1)) begin
               state_in = ST_EMIT_RD;
            end else begin
               last_in  = last_ff - AW'(1);
               state_in = ST_PRIME;
            end
         end
         ST_EMIT_RD: begin
            ram_raddr = j_ff;
            state_in  = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            out_value_in = ram_rdata;
            out_last_in  = (j_ff == top_ff);
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (rsp_fire) begin
               if (out_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  j_in     = j_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("input ready while a result is pending");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MaxCount)
      else $error("fill count beyond capacity");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff != '0) && (k_ff <= last_ff))
      else $error("scan index out of pass range");

   a_final_beat_ends_batch: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |=> (state_ff == ST_IDLE) && (count_ff == '0) && !dropped_ff)
      else $error("batch state not cleared after final beat");

   a_emit_within_batch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD) |-> (j_ff <= top_ff))
      else $error("emit index past end of batch");

endmodule

// File: tb/tb_top.sv
// testbench for merge_and_bubble_sort_core: directed and random batches checked by a sorting model
module tb_top;
   import mbs_pkg::*;

   localparam int STORE_DEPTH  = 64;
   localparam int IDLE_PCT     = 32;
   localparam int RANDOM_ITEMS = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 40;

   typedef struct packed {
      value_type value;
      logic      last;
      logic      overflow;
   } sorted_beat_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;  // [6:0] value, [7] zero
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // [6:0] sorted_value, [7] zero
   logic              rsp_tlast;
   logic              rsp_tuser;        // [0] overflow

   // model of the batch store
   value_type        held_values [STORE_DEPTH];
   int               fill_count    = 0;
   bit               batch_dropped = 1'b0;
   sorted_beat_type  sorted_queue [$];

   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   bit          steady      = 1'b0;  // no idling on either side while set

   merge_and_bubble_sort_core #(.MAX_ITEMS(STORE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // store one accepted value; on end of batch sort and queue the expected beats
   function automatic void absorb_value(input value_type v, input bit last);
      value_type t;
      if (fill_count < STORE_DEPTH) begin
         held_values[fill_count] = v;
         fill_count++;
      end else begin
         batch_dropped = 1'b1;
      end
      if (last) begin
         for (int pass = 0; pass + 1 < fill_count; pass++) begin
            for (int k = 0; k + 1 < fill_count - pass; k++) begin
               if (held_values[k] > held_values[k+1]) begin
                  t                = held_values[k];
                  held_values[k]   = held_values[k+1];
                  held_values[k+1] = t;
               end
            end
         end
         for (int k = 0; k < fill_count; k++) begin
            sorted_queue.push_back('{held_values[k], (k + 1 == fill_count), batch_dropped});
         end
         fill_count    = 0;
         batch_dropped = 1'b0;
      end
   endfunction

   // valid stays high across back-to-back beats; it only drops on an idle cycle
   task automatic send_item(input value_type v, input bit last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, v};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_value(v, last);
   endtask

   task automatic send_batch(input value_type vals [$]);
      foreach (vals[k]) send_item(vals[k], k == vals.size() - 1);
   endtask

   // single-value batches at the range limits and outside the nominal range
   task automatic test_edge_values();
      send_batch('{value_type'(0)});
      send_batch('{value_type'(127)});
      send_batch('{value_type'(1)});
      send_batch('{value_type'(100)});
   endtask

   // three separate batches: reversed values, duplicates, out-of-range values
   task automatic test_unsorted_batches();
      send_batch('{value_type'(127), value_type'(101), value_type'(100), value_type'(55),
                   value_type'(55), value_type'(64), value_type'(1), value_type'(0)});
      send_batch('{value_type'(2), value_type'(3), value_type'(3), value_type'(9)});
      send_batch('{value_type'(9), value_type'(3), value_type'(3), value_type'(2)});
   endtask

   // exactly full store, then a batch whose tail and end beat are dropped
   task automatic test_store_capacity();
      value_type batch [$];
      steady = 1'b1;
      for (int k = 0; k < STORE_DEPTH; k++) batch.push_back(value_type'((STORE_DEPTH - k) * 2 - 1));
      send_batch(batch);
      batch.delete();
      for (int k = 0; k < STORE_DEPTH + 2; k++) batch.push_back(value_type'($urandom_range(127)));
      send_batch(batch);
      steady = 1'b0;
   endtask

   // mostly short batches, now and then one near or past capacity
   task automatic test_random_batches();
      value_type batch [$];
      int        sent = 0;
      int        n;
      int        lo;
      int        hi;
      while (sent < RANDOM_ITEMS) begin
         batch.delete();
         n = ($urandom_range(9) == 0) ? $urandom_range(72, 60) : $urandom_range(16, 1);
         case ($urandom_range(2))
            0: begin lo = 0; hi = 127; end
            1: begin lo = 1; hi = 100; end
            default: begin lo = 0; hi = 7; end  // narrow range forces duplicates
         endcase
         for (int k = 0; k < n; k++) batch.push_back(value_type'($urandom_range(hi, lo)));
         send_batch(batch);
         sent += n;
      end
   endtask

   // result side: random backpressure and comparison with the oldest expected beat
   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected beat, expected none, actual value %0d last %0b ovf %0b",
                        $time, rsp_tdata[VALUE_W-1:0], rsp_tlast, rsp_tuser);
         end else begin
            want = sorted_queue.pop_front();
            if (rsp_tdata[VALUE_W-1:0] !== want.value || rsp_tlast !== want.last ||
                rsp_tuser !== want.overflow) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: expected value %0d last %0b ovf %0b, actual value %0d last %0b ovf %0b",
                           $time, want.value, want.last, want.overflow,
                           rsp_tdata[VALUE_W-1:0], rsp_tlast, rsp_tuser);
            end
         end
      end
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_edge_values();
      test_unsorted_batches();
      test_store_capacity();
      test_random_batches();
      req_tvalid <= 1'b0;
      while (sorted_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
